// ----- rtl/core/subset_8080_core_step_assert.svh -----
// Assertion macros for the core step block
`ifndef SUBSET_8080_CORE_STEP_ASSERT_SVH
`define SUBSET_8080_CORE_STEP_ASSERT_SVH

// Assert an implication that holds in the next cycle
`define S80_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

// Assert an implication in the same cycle
`define S80_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/s80_pkg.sv -----
// ----------------------------------------------------------------------------
// s80_pkg
// Shared constants and types of the 8080-style core step block.
// ----------------------------------------------------------------------------
package s80_pkg;
   localparam int MemDepthDefault = 16384;
   localparam logic [7:0] OP_NOP  = 8'h00;
   localparam logic [7:0] OP_DCRB = 8'h05;
   localparam logic [7:0] OP_LXID = 8'h11;
   localparam logic [7:0] OP_INXD = 8'h13;
   localparam logic [7:0] OP_LDAX = 8'h1a;
   localparam logic [7:0] OP_LXIH = 8'h21;
   localparam logic [7:0] OP_INXH = 8'h23;
   localparam logic [7:0] OP_LXIS = 8'h31;
   localparam logic [7:0] OP_HLTM = 8'h76;
   localparam logic [7:0] OP_JNZ  = 8'hc2;
   localparam logic [7:0] OP_JMP  = 8'hc3;
   localparam logic [7:0] OP_RET  = 8'hc9;
   localparam logic [7:0] OP_CALL = 8'hcd;
   localparam logic [7:0] OP_CPI  = 8'hfe;
   localparam logic       REQ_LOAD = 1'b0;

   // memory port request from sequencer to memory
   typedef struct packed {
      logic        we;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;
endpackage

// ----- rtl/core/s80_mem.sv -----
// ----------------------------------------------------------------------------
// s80_mem
// Byte memory, one port, registered read, clearing pass after reset.
// ----------------------------------------------------------------------------
module s80_mem import s80_pkg::*; #(
   parameter int MEM_DEPTH = MemDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata,
   output logic        clr_done
);
   localparam int AW = $clog2(MEM_DEPTH);
   localparam logic [22:0] RECIP_SCALE =
      23'(((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH));
   logic [7:0]    mem_array [MEM_DEPTH];
   logic [AW:0]   clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0] addr;
   logic [38:0]   prod;
   logic [6:0]    quo;
   logic [23:0]   red;

   assign clr_done = clr_cnt_ff[AW];
   // reduce modulo depth: the rounded-up reciprocal gives the exact quotient
   // for every 16-bit address
   always_comb begin
      prod = 39'(mem_req.addr) * 39'(RECIP_SCALE);
      quo = prod[38:32];
      red = 24'(mem_req.addr) - 24'(quo) * 24'(MEM_DEPTH);
      addr = red[AW-1:0];
      clr_cnt_in = clr_cnt_ff;
      if (!clr_done) clr_cnt_in = clr_cnt_ff + (AW+1)'(1);
      if (clr_cnt_in == (AW+1)'(MEM_DEPTH)) clr_cnt_in[AW] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else clr_cnt_ff <= clr_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (!clr_done) begin
         mem_array[clr_cnt_ff[AW-1:0]] <= 8'h00;
      end else if (mem_req.we) begin
         mem_array[addr] <= mem_req.wdata;
      end
      rdata <= mem_array[addr];
   end
endmodule

// ----- rtl/core/s80_seq.sv -----
// ----------------------------------------------------------------------------
// s80_seq
// Instruction sequencer: fetch, operand reads, stack access, register file.
// ----------------------------------------------------------------------------
module s80_seq import s80_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        clr_done,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [13:0] load_addr,
   input  logic [7:0]  load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_opcode,
   output logic [15:0] rsp_prog_counter,
   output logic [7:0]  rsp_accum,
   output logic [15:0] rsp_pair_bc,
   output logic [15:0] rsp_pair_de,
   output logic [15:0] rsp_pair_hl,
   output logic [15:0] rsp_stack_ptr,
   output logic [3:0]  rsp_flag_bits,
   output logic        rsp_halted,
   output mem_req_type mem_req,
   input  logic [7:0]  rdata
);
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_OP   = 7'b0000010,
      ST_B1   = 7'b0000100,
      ST_B2   = 7'b0001000,
      ST_M    = 7'b0010000,
      ST_PUSH = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type   st_ff, st_in;
   logic [7:0]  op_ff, op_in, lo_ff, lo_in;
   logic [7:0]  a_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff;
   logic [7:0]  a_in, b_in, c_in, d_in, e_in, h_in, l_in;
   logic [15:0] pc_ff, pc_in, sp_ff, sp_in, ra_ff, ra_in;
   logic [3:0]  f_ff, f_in;
   logic        hlt_ff, hlt_in, vld_ff, vld_in;
   logic [7:0]  src, cmpv;
   logic        take, need_m, is_alu, is_mvi, is_mov;
   logic [2:0]  dst;

   assign take = req_valid && !req_stall;
   assign req_stall = !clr_done || st_ff != ST_IDLE || vld_ff;
   assign rsp_valid = vld_ff;
   assign rsp_opcode = op_ff;
   assign rsp_prog_counter = pc_ff;
   assign rsp_accum = a_ff;
   assign rsp_pair_bc = {b_ff, c_ff};
   assign rsp_pair_de = {d_ff, e_ff};
   assign rsp_pair_hl = {h_ff, l_ff};
   assign rsp_stack_ptr = sp_ff;
   assign rsp_flag_bits = f_ff;
   assign rsp_halted = hlt_ff;

   assign is_mvi = (op_ff & 8'hc7) == 8'h06;
   assign is_mov = op_ff[7:6] == 2'b01;
   assign is_alu = op_ff[7:6] == 2'b10;
   assign dst = op_ff[5:3];
   assign need_m = (is_mov || is_alu) && op_ff[2:0] == 3'd6;

   always_comb begin
      case (op_ff[2:0])
         3'd0: src = b_ff;
         3'd1: src = c_ff;
         3'd2: src = d_ff;
         3'd3: src = e_ff;
         3'd4: src = h_ff;
         3'd5: src = l_ff;
         3'd6: src = rdata;
         default: src = a_ff;
      endcase
   end

   function automatic logic [3:0] cmp_f(input logic [7:0] a, input logic [7:0] v);
      cmp_f = {a == v, 1'b1, a[3:0] < v[3:0], a < v};
   endfunction

   always_comb begin
      st_in = st_ff; op_in = op_ff; lo_in = lo_ff; ra_in = ra_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      e_in = e_ff; h_in = h_ff; l_in = l_ff;
      pc_in = pc_ff; sp_in = sp_ff; f_in = f_ff; hlt_in = hlt_ff;
      vld_in = vld_ff && rsp_stall;
      mem_req = '{we: 1'b0, addr: pc_ff, wdata: load_data};
      cmpv = src;
      case (st_ff)
         ST_IDLE: begin
            if (take) begin
               op_in = OP_NOP;
               if (req_type == REQ_LOAD) begin
                  mem_req = '{we: 1'b1, addr: {2'b00, load_addr}, wdata: load_data};
                  vld_in = 1'b1;
               end else if (hlt_ff) begin
                  vld_in = 1'b1;
               end else begin
                  pc_in = pc_ff + 16'd1;
                  st_in = ST_OP;
               end
            end
         end
         ST_OP: begin
            // opcode arrives; issue first operand read, data read or return-address push
            op_in = rdata;
            st_in = ST_DONE;
            if ((rdata & 8'hc7) == 8'h06 || rdata == OP_LXID || rdata == OP_LXIH
                || rdata == OP_LXIS || rdata == OP_JNZ || rdata == OP_JMP
                || (rdata & 8'hc7) == 8'hc6) begin
               st_in = ST_B1;
               pc_in = pc_ff + 16'd1;
            end else if (rdata == OP_CALL) begin
               ra_in = pc_ff + 16'd2;
               sp_in = sp_ff - 16'd2;
               mem_req = '{we: 1'b1, addr: sp_ff - 16'd2, wdata: ra_in[7:0]};
               st_in = ST_PUSH;
            end else if (rdata == OP_RET) begin
               mem_req.addr = sp_ff;
               st_in = ST_B1;
            end else if (rdata == OP_LDAX) begin
               mem_req.addr = {d_ff, e_ff};
               st_in = ST_M;
            end else if ((rdata[7:6] == 2'b01 || rdata[7:6] == 2'b10)
                         && rdata[2:0] == 3'd6) begin
               mem_req.addr = {h_ff, l_ff};
               st_in = ST_M;
            end
         end
         ST_PUSH: begin
            mem_req = '{we: 1'b1, addr: sp_ff + 16'd1, wdata: ra_ff[15:8]};
            st_in = ST_B2;
         end
         ST_B2: begin
            // call target: read low byte after the push
            st_in = ST_B1;
            pc_in = pc_ff + 16'd1;
         end
         ST_B1: begin
            lo_in = rdata;
            if (is_mvi) begin
               mem_req = '{we: dst == 3'd6, addr: {h_ff, l_ff}, wdata: rdata};
               case (dst)
                  3'd0: b_in = rdata;
                  3'd1: c_in = rdata;
                  3'd2: d_in = rdata;
                  3'd3: e_in = rdata;
                  3'd4: h_in = rdata;
                  3'd5: l_in = rdata;
                  3'd7: a_in = rdata;
                  default: ;
               endcase
               st_in = ST_DONE;
            end else if ((op_ff & 8'hc7) == 8'hc6) begin
               if (op_ff == OP_CPI) f_in = cmp_f(a_ff, rdata);
               st_in = ST_DONE;
            end else begin
               if (op_ff == OP_RET) mem_req.addr = sp_ff + 16'd1;
               else if (op_ff == OP_CALL) mem_req.addr = pc_ff;
               else pc_in = pc_ff + 16'd1;
               st_in = ST_M;
            end
         end
         ST_M: begin
            st_in = ST_DONE;
            if (op_ff == OP_LDAX) a_in = rdata;
            else if (is_mov) begin
               mem_req = '{we: dst == 3'd6, addr: {h_ff, l_ff}, wdata: src};
               case (dst)
                  3'd0: b_in = src;
                  3'd1: c_in = src;
                  3'd2: d_in = src;
                  3'd3: e_in = src;
                  3'd4: h_in = src;
                  3'd5: l_in = src;
                  3'd7: a_in = src;
                  default: ;
               endcase
            end else if (is_alu) begin
               if (dst == 3'd7) f_in = cmp_f(a_ff, src);
            end else if (op_ff == OP_LXID) begin
               d_in = rdata; e_in = lo_ff;
            end else if (op_ff == OP_LXIH) begin
               h_in = rdata; l_in = lo_ff;
            end else if (op_ff == OP_LXIS) begin
               sp_in = {rdata, lo_ff};
            end else if (op_ff == OP_JMP || op_ff == OP_CALL) begin
               pc_in = {rdata, lo_ff};
            end else if (op_ff == OP_JNZ) begin
               if (!f_ff[3]) pc_in = {rdata, lo_ff};
            end else if (op_ff == OP_RET) begin
               pc_in = {rdata, lo_ff};
               sp_in = sp_ff + 16'd2;
            end
         end
         ST_DONE: begin
            // every op finishes here; single-byte ops without memory operand are executed here
            if (!need_m && (is_mov || is_alu) && !(is_mvi)) begin
               if (is_mov) begin
                  // move a register to a register, or to memory at HL when the destination is M
                  mem_req = '{we: dst == 3'd6, addr: {h_ff, l_ff}, wdata: src};
                  case (dst)
                     3'd0: b_in = src;
                     3'd1: c_in = src;
                     3'd2: d_in = src;
                     3'd3: e_in = src;
                     3'd4: h_in = src;
                     3'd5: l_in = src;
                     3'd7: a_in = src;
                     default: ;
                  endcase
               end else if (dst == 3'd7) f_in = cmp_f(a_ff, cmpv);
            end else if (op_ff == OP_DCRB) begin
               b_in = b_ff - 8'd1;
               f_in = {b_ff == 8'd1, 1'b1, b_ff[3:0] == 4'd0, f_ff[0]};
            end else if (op_ff == OP_INXD) begin
               {d_in, e_in} = {d_ff, e_ff} + 16'd1;
            end else if (op_ff == OP_INXH) begin
               {h_in, l_in} = {h_ff, l_ff} + 16'd1;
            end else if (!(op_ff == OP_NOP || is_mvi || is_mov || is_alu
                         || (op_ff & 8'hc7) == 8'hc6 || op_ff == OP_LXID
                         || op_ff == OP_LXIH || op_ff == OP_LXIS || op_ff == OP_LDAX
                         || op_ff == OP_JNZ || op_ff == OP_JMP || op_ff == OP_RET
                         || op_ff == OP_CALL)) begin
               hlt_in = 1'b1;
            end
            vld_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // ST_DONE is reached again after memory-operand paths; mark them done
   logic fin_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; vld_ff <= 1'b0; hlt_ff <= 1'b0; fin_ff <= 1'b0;
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0; e_ff <= '0;
         h_ff <= '0; l_ff <= '0; pc_ff <= '0; sp_ff <= '0; f_ff <= '0;
         op_ff <= '0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in; hlt_ff <= hlt_in;
         op_ff <= op_in; pc_ff <= pc_in; sp_ff <= sp_in;
         fin_ff <= (st_ff == ST_M || st_ff == ST_B1) && st_in == ST_DONE;
         if (st_ff == ST_DONE && fin_ff) begin
            // operand work already applied; only finish
            f_ff <= f_ff; a_ff <= a_ff; b_ff <= b_ff; c_ff <= c_ff;
            d_ff <= d_ff; e_ff <= e_ff; h_ff <= h_ff; l_ff <= l_ff;
         end else begin
            a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
            e_ff <= e_in; h_ff <= h_in; l_ff <= l_in; f_ff <= f_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      ra_ff <= ra_in;
   end
endmodule

// ----- rtl/core/subset_8080_core_step.sv -----
// ----------------------------------------------------------------------------
// subset_8080_core_step
// 8080-style core step with its own byte memory.
// ----------------------------------------------------------------------------
// The length of a step is set by the number of accesses to the single memory port
// (opcode, operands, stack), each read being registered. After reset the memory
// is cleared and no request is taken until then.
module subset_8080_core_step import s80_pkg::*; #(
   parameter int MEM_DEPTH = MemDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [13:0] req_load_addr,
   input  logic [7:0]  req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_opcode,
   output logic [15:0] rsp_prog_counter,
   output logic [7:0]  rsp_accum,
   output logic [15:0] rsp_pair_bc,
   output logic [15:0] rsp_pair_de,
   output logic [15:0] rsp_pair_hl,
   output logic [15:0] rsp_stack_ptr,
   output logic [3:0]  rsp_flag_bits,
   output logic        rsp_halted
);
   mem_req_type mem_req;
   logic [7:0]  rdata;
   logic        clr_done;

   s80_mem #(.MEM_DEPTH(MEM_DEPTH)) u_mem (
      .clock, .reset, .mem_req, .rdata, .clr_done);

   s80_seq u_seq (
      .clock, .reset, .clr_done, .req_valid, .req_stall, .req_type,
      .load_addr(req_load_addr), .load_data(req_load_data),
      .rsp_valid, .rsp_stall, .rsp_opcode, .rsp_prog_counter, .rsp_accum,
      .rsp_pair_bc, .rsp_pair_de, .rsp_pair_hl, .rsp_stack_ptr,
      .rsp_flag_bits, .rsp_halted, .mem_req, .rdata);
endmodule

// ----- rtl/core/s80_chk.sv -----
// ----------------------------------------------------------------------------
// s80_chk
// Port checker for the core step block.
// ----------------------------------------------------------------------------
`include "subset_8080_core_step_assert.svh"
module s80_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_opcode,
   input logic        rsp_halted
);
   `S80_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `S80_ASSERT_NEXT(a_keep, clock, reset, rsp_valid && rsp_stall, $stable(rsp_opcode))
   `S80_ASSERT_NOW(a_busy, clock, reset, rsp_valid, req_stall)
   `S80_ASSERT_NEXT(a_halt, clock, reset, rsp_valid && rsp_halted, rsp_halted)
endmodule

bind subset_8080_core_step s80_chk u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_opcode, .rsp_halted);
